// ===== hdl/pid_motor_drive_defines.svh =====
// Assertion helpers shared by the pid_motor_drive RTL.
`ifndef PID_MOTOR_DRIVE_DEFINES_SVH
`define PID_MOTOR_DRIVE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PMD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PMD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/pmd_pkg.sv =====
`default_nettype none

package pmd_pkg;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP_GAIN,
      CSR_KI_GAIN,
      CSR_KD_GAIN,
      CSR_INTEGRATOR_MIN,
      CSR_INTEGRATOR_MAX,
      CSR_TARGET
   } csr_idx_type;

   localparam int DUTY_W     = 7;
   localparam int DUTY_LIMIT = 100;

   localparam int KP_GAIN_RESET        = 2560;
   localparam int KI_GAIN_RESET        = 512;
   localparam int KD_GAIN_RESET        = 2560;
   localparam int INTEGRATOR_MIN_RESET = -5;
   localparam int INTEGRATOR_MAX_RESET = 5;
   localparam int TARGET_RESET         = 45;

   // Per-stage flow control: global advance plus valid of the upstream stage.
   typedef struct packed {
      logic advance;
      logic valid;
   } stage_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/pmd_req_if.sv =====
`default_nettype none

interface pmd_req_if #(
   parameter int DATA_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] measured;

   modport source (output valid, output measured, input ready);
   modport sink   (input valid, input measured, output ready);
endinterface

`default_nettype wire

// ===== hdl/pmd_rsp_if.sv =====
`default_nettype none

interface pmd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pmd_pkg::DUTY_W-1:0]    duty;
   logic                          forward;

   modport source (output valid, output duty, output forward, input ready);
   modport sink   (input valid, input duty, input forward, output ready);
endinterface

`default_nettype wire

// ===== hdl/pmd_state.sv =====
`default_nettype none

`include "pid_motor_drive_defines.svh"

module pmd_state #(
   parameter int DATA_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pmd_pkg::stage_ctl_type        ctl,
   input  wire logic                          clear,
   input  wire logic signed [DATA_WIDTH-1:0]  measured,
   input  wire logic signed [DATA_WIDTH-1:0]  target,
   input  wire logic signed [DATA_WIDTH-1:0]  integrator_min,
   input  wire logic signed [DATA_WIDTH-1:0]  integrator_max,
   output logic                               valid_o,
   output logic signed [DATA_WIDTH:0]         err_o,
   output logic signed [DATA_WIDTH-1:0]       acc_o,
   output logic signed [DATA_WIDTH+1:0]       diff_o
);
   localparam int ERR_W = DATA_WIDTH + 1;
   localparam int SUM_W = DATA_WIDTH + 2;

   logic                          accept;
   logic signed [ERR_W-1:0]       err;
   logic signed [SUM_W-1:0]       acc_raw;
   logic signed [DATA_WIDTH-1:0]  acc_in;
   logic signed [SUM_W-1:0]       diff;

   logic signed [DATA_WIDTH-1:0]  error_sum_ff;
   logic signed [ERR_W-1:0]       prev_err_ff;
   logic                          valid_ff;
   logic signed [ERR_W-1:0]       err_ff;
   logic signed [DATA_WIDTH-1:0]  acc_ff;
   logic signed [SUM_W-1:0]       diff_ff;

   assign accept = ctl.advance && ctl.valid;

   assign err     = ERR_W'(target) - ERR_W'(measured);
   assign acc_raw = SUM_W'(error_sum_ff) + SUM_W'(err);
   assign diff    = SUM_W'(err) - SUM_W'(prev_err_ff);

   // Upper bound tested first so inverted limits resolve like the spec.
   always_comb begin
      if (acc_raw > SUM_W'(integrator_max)) begin
         acc_in = integrator_max;
      end else if (acc_raw < SUM_W'(integrator_min)) begin
         acc_in = integrator_min;
      end else begin
         acc_in = acc_raw[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
      end else if (accept) begin
         error_sum_ff <= acc_in;
         prev_err_ff  <= err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff  <= err;
         acc_ff  <= acc_in;
         diff_ff <= diff;
      end
   end

   assign valid_o = valid_ff;
   assign err_o   = err_ff;
   assign acc_o   = acc_ff;
   assign diff_o  = diff_ff;

   `PMD_ASSERT_NEXT(a_clear_state, clock, reset, clear, error_sum_ff == '0 && prev_err_ff == '0, "setpoint write did not clear integrator state")
   `PMD_ASSERT_NEXT(a_hold_state, clock, reset, !accept && !clear, $stable(error_sum_ff) && $stable(prev_err_ff), "integrator state moved without an item")
   `PMD_ASSERT_NEXT(a_prev_tracks, clock, reset, accept && !clear, prev_err_ff == err_ff, "previous error differs from staged error")

endmodule

`default_nettype wire

// ===== hdl/pmd_mult.sv =====
`default_nettype none

module pmd_mult #(
   parameter int DATA_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pmd_pkg::stage_ctl_type        ctl,
   input  wire logic signed [DATA_WIDTH:0]    err,
   input  wire logic signed [DATA_WIDTH-1:0]  acc,
   input  wire logic signed [DATA_WIDTH+1:0]  diff,
   input  wire logic signed [DATA_WIDTH-1:0]  kp_gain,
   input  wire logic signed [DATA_WIDTH-1:0]  ki_gain,
   input  wire logic signed [DATA_WIDTH-1:0]  kd_gain,
   output logic                               valid_o,
   output logic signed [2*DATA_WIDTH:0]       p_term_o,
   output logic signed [2*DATA_WIDTH-1:0]     i_term_o,
   output logic signed [2*DATA_WIDTH+1:0]     d_term_o
);
   localparam int P_W = 2 * DATA_WIDTH + 1;
   localparam int I_W = 2 * DATA_WIDTH;
   localparam int D_W = 2 * DATA_WIDTH + 2;

   logic signed [P_W-1:0] p_prod;
   logic signed [I_W-1:0] i_prod;
   logic signed [D_W-1:0] d_prod;

   logic                  valid_ff;
   logic signed [P_W-1:0] p_ff;
   logic signed [I_W-1:0] i_ff;
   logic signed [D_W-1:0] d_ff;

   // Products are exact in Q.frac; no rounding anywhere.
   assign p_prod = P_W'(kp_gain) * P_W'(err);
   assign i_prod = I_W'(ki_gain) * I_W'(acc);
   assign d_prod = D_W'(kd_gain) * D_W'(diff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance && ctl.valid) begin
         p_ff <= p_prod;
         i_ff <= i_prod;
         d_ff <= d_prod;
      end
   end

   assign valid_o  = valid_ff;
   assign p_term_o = p_ff;
   assign i_term_o = i_ff;
   assign d_term_o = d_ff;

endmodule

`default_nettype wire

// ===== hdl/pmd_out.sv =====
`default_nettype none

module pmd_out #(
   parameter int DATA_WIDTH     = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          valid_i,
   input  wire logic signed [2*DATA_WIDTH:0]  p_term,
   input  wire logic signed [2*DATA_WIDTH-1:0] i_term,
   input  wire logic signed [2*DATA_WIDTH+1:0] d_term,
   output logic                               advance_o,
   pmd_rsp_if.source                          rsp
);
   localparam int SUM_W = (2 * DATA_WIDTH + 4 > GAIN_FRAC_BITS + 8) ?
                          2 * DATA_WIDTH + 4 : GAIN_FRAC_BITS + 8;
   localparam logic signed [SUM_W-1:0] LIM =
      SUM_W'(pmd_pkg::DUTY_LIMIT) << GAIN_FRAC_BITS;
   localparam logic signed [SUM_W-1:0] NEG_LIM = -LIM;

   logic signed [SUM_W-1:0]     sum;
   logic        [SUM_W-1:0]     mag;
   logic [pmd_pkg::DUTY_W-1:0]  duty_in;
   logic                        forward_in;
   logic                        advance;

   logic                        valid_ff;
   logic [pmd_pkg::DUTY_W-1:0]  duty_ff;
   logic                        forward_ff;

   assign sum = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);

   // Clamp to +-100 in Q.frac, then absolute value.
   always_comb begin
      if (sum > LIM) begin
         mag = LIM;
      end else if (sum < NEG_LIM) begin
         mag = LIM;
      end else if (sum < 0) begin
         mag = -sum;
      end else begin
         mag = sum;
      end
   end

   assign duty_in    = mag[GAIN_FRAC_BITS +: pmd_pkg::DUTY_W];
   assign forward_in = (sum > 0);

   // Output register frees up when empty or being taken this cycle.
   assign advance = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && valid_i) begin
         duty_ff    <= duty_in;
         forward_ff <= forward_in;
      end
   end

   assign advance_o   = advance;
   assign rsp.valid   = valid_ff;
   assign rsp.duty    = duty_ff;
   assign rsp.forward = forward_ff;

endmodule

`default_nettype wire

// ===== hdl/pid_motor_drive.sv =====
// PID motor drive with integrator clamp.
//
// req_chan carries one signed measured sample per item (valid/ready).
// rsp_chan returns exactly one item per sample: duty (0..100 percent) and
// forward (set when the unclamped drive sum is above zero).
// csr_we/csr_idx/csr_wdata write the gains, integrator limits and setpoint;
// writing the setpoint also clears the integrator and the previous error.
// Write registers only while no items are in flight.
//
// Pipeline from accept to rsp valid: error/integrator stage, multiplier
// stage, sum-clamp output register. Throughput: one item per cycle while
// the receiver keeps up; the integrator add-and-clamp is combinational.
// When the receiver stalls, all three stages hold and req_chan.ready drops
// in the same cycle; nothing is dropped or repeated.
//
// Reset (synchronous, active high) empties the pipeline, loads default
// register values (kp 10.0, ki 2.0, kd 10.0, limits -5..5, setpoint 45)
// and clears the integrator state.
`default_nettype none

`include "pid_motor_drive_defines.svh"

module pid_motor_drive #(
   parameter int DATA_WIDTH     = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   pmd_req_if.sink                              req_chan,
   pmd_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [pmd_pkg::CSR_IDX_W-1:0]   csr_idx,
   input  wire logic [DATA_WIDTH-1:0]           csr_wdata
);
   logic signed [DATA_WIDTH-1:0] kp_gain_ff;
   logic signed [DATA_WIDTH-1:0] ki_gain_ff;
   logic signed [DATA_WIDTH-1:0] kd_gain_ff;
   logic signed [DATA_WIDTH-1:0] integrator_min_ff;
   logic signed [DATA_WIDTH-1:0] integrator_max_ff;
   logic signed [DATA_WIDTH-1:0] target_ff;

   logic                         advance;
   logic                         target_clear;
   pmd_pkg::stage_ctl_type       state_ctl;
   pmd_pkg::stage_ctl_type       mult_ctl;

   logic                          state_valid;
   logic signed [DATA_WIDTH:0]    err;
   logic signed [DATA_WIDTH-1:0]  acc;
   logic signed [DATA_WIDTH+1:0]  diff;

   logic                           mult_valid;
   logic signed [2*DATA_WIDTH:0]   p_term;
   logic signed [2*DATA_WIDTH-1:0] i_term;
   logic signed [2*DATA_WIDTH+1:0] d_term;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_gain_ff        <= DATA_WIDTH'(pmd_pkg::KP_GAIN_RESET);
         ki_gain_ff        <= DATA_WIDTH'(pmd_pkg::KI_GAIN_RESET);
         kd_gain_ff        <= DATA_WIDTH'(pmd_pkg::KD_GAIN_RESET);
         integrator_min_ff <= DATA_WIDTH'(pmd_pkg::INTEGRATOR_MIN_RESET);
         integrator_max_ff <= DATA_WIDTH'(pmd_pkg::INTEGRATOR_MAX_RESET);
         target_ff         <= DATA_WIDTH'(pmd_pkg::TARGET_RESET);
      end else if (csr_we) begin
         case (pmd_pkg::csr_idx_type'(csr_idx))
            pmd_pkg::CSR_KP_GAIN:        kp_gain_ff        <= csr_wdata;
            pmd_pkg::CSR_KI_GAIN:        ki_gain_ff        <= csr_wdata;
            pmd_pkg::CSR_KD_GAIN:        kd_gain_ff        <= csr_wdata;
            pmd_pkg::CSR_INTEGRATOR_MIN: integrator_min_ff <= csr_wdata;
            pmd_pkg::CSR_INTEGRATOR_MAX: integrator_max_ff <= csr_wdata;
            pmd_pkg::CSR_TARGET:         target_ff         <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign target_clear = csr_we &&
                         (pmd_pkg::csr_idx_type'(csr_idx) == pmd_pkg::CSR_TARGET);

   assign req_chan.ready = advance;

   assign state_ctl.advance = advance;
   assign state_ctl.valid   = req_chan.valid;
   assign mult_ctl.advance  = advance;
   assign mult_ctl.valid    = state_valid;

   pmd_state #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_state (
      .clock          (clock),
      .reset          (reset),
      .ctl            (state_ctl),
      .clear          (target_clear),
      .measured       (req_chan.measured),
      .target         (target_ff),
      .integrator_min (integrator_min_ff),
      .integrator_max (integrator_max_ff),
      .valid_o        (state_valid),
      .err_o          (err),
      .acc_o          (acc),
      .diff_o         (diff)
   );

   pmd_mult #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mult (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mult_ctl),
      .err      (err),
      .acc      (acc),
      .diff     (diff),
      .kp_gain  (kp_gain_ff),
      .ki_gain  (ki_gain_ff),
      .kd_gain  (kd_gain_ff),
      .valid_o  (mult_valid),
      .p_term_o (p_term),
      .i_term_o (i_term),
      .d_term_o (d_term)
   );

   pmd_out #(
      .DATA_WIDTH     (DATA_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .valid_i   (mult_valid),
      .p_term    (p_term),
      .i_term    (i_term),
      .d_term    (d_term),
      .advance_o (advance),
      .rsp       (rsp_chan)
   );

   `PMD_ASSERT_IMP(a_duty_range, clock, reset, rsp_chan.valid, rsp_chan.duty <= pmd_pkg::DUTY_W'(pmd_pkg::DUTY_LIMIT), "duty above limit")

endmodule

`default_nettype wire

// ===== verif/pid_motor_drive_tb.sv =====
module pid_motor_drive_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pmd_pkg::*;

   localparam int DATA_W         = 16;
   localparam int GAIN_FRAC      = 8;
   localparam int NUM_PHASES     = 9;
   localparam int ITEMS_PER_PHASE = 48;
   localparam int NUM_ROWS       = 20;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD      = 90;

   // Indexes past the last register; writes there must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(7);

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              forward;
   } drive_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] meas;
      logic                     typed;
      logic [DUTY_W-1:0]        duty;
      logic                     forward;
   } sample_row_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [DATA_W-1:0]    csr_wdata;

   pmd_req_if #(.DATA_WIDTH(DATA_W)) req_chan ();
   pmd_rsp_if rsp_chan ();

   pid_motor_drive #(
      .DATA_WIDTH     (DATA_W),
      .GAIN_FRAC_BITS (GAIN_FRAC)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // Controller image: registers and loop state.
   logic signed [DATA_W-1:0] kp_q, ki_q, kd_q, imin_q, imax_q, target_q;
   logic signed [DATA_W-1:0] integ_q;
   logic signed [DATA_W:0]   prev_err_q;

   drive_type pending_drive_q [$];

   int mismatches     = 0;
   int drives_checked = 0;
   int samples_sent   = 0;
   int settings_used  = 1;
   int long_holds     = 0;
   int input_stalls   = 0;
   int quiet_cycles   = 0;
   int burst_left     = 0;
   bit gaps_on        = 1'b1;

   // Defaults from reset; first four rows have results easy to work out by hand.
   sample_row_type sample_table [NUM_ROWS] = '{
      '{16'sd45,    1'b1, 7'd0,   1'b0},
      '{16'sh8000,  1'b1, 7'd100, 1'b1},
      '{16'sh7FFF,  1'b1, 7'd100, 1'b0},
      '{16'sd45,    1'b1, 7'd100, 1'b1},
      '{16'sd44,    1'b0, 7'd0,   1'b0},
      '{16'sd46,    1'b0, 7'd0,   1'b0},
      '{16'sd43,    1'b0, 7'd0,   1'b0},
      '{16'sd47,    1'b0, 7'd0,   1'b0},
      '{16'sd40,    1'b0, 7'd0,   1'b0},
      '{16'sd50,    1'b0, 7'd0,   1'b0},
      '{16'sd45,    1'b0, 7'd0,   1'b0},
      '{16'sd45,    1'b0, 7'd0,   1'b0},
      '{16'sd0,     1'b0, 7'd0,   1'b0},
      '{-16'sd1,    1'b0, 7'd0,   1'b0},
      '{16'sd1,     1'b0, 7'd0,   1'b0},
      '{-16'sd300,  1'b0, 7'd0,   1'b0},
      '{16'sd300,   1'b0, 7'd0,   1'b0},
      '{16'sh7FFE,  1'b0, 7'd0,   1'b0},
      '{16'sh8001,  1'b0, 7'd0,   1'b0},
      '{16'sd45,    1'b0, 7'd0,   1'b0}
   };

   always #5 clock = ~clock;

   task automatic reset_image();
      kp_q       = DATA_W'(KP_GAIN_RESET);
      ki_q       = DATA_W'(KI_GAIN_RESET);
      kd_q       = DATA_W'(KD_GAIN_RESET);
      imin_q     = DATA_W'(INTEGRATOR_MIN_RESET);
      imax_q     = DATA_W'(INTEGRATOR_MAX_RESET);
      target_q   = DATA_W'(TARGET_RESET);
      integ_q    = '0;
      prev_err_q = '0;
   endtask

   task automatic apply_reg_write(input logic [CSR_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] data);
      case (idx)
         CSR_KP_GAIN:        kp_q = data;
         CSR_KI_GAIN:        ki_q = data;
         CSR_KD_GAIN:        kd_q = data;
         CSR_INTEGRATOR_MIN: imin_q = data;
         CSR_INTEGRATOR_MAX: imax_q = data;
         CSR_TARGET: begin
            target_q   = data;
            integ_q    = '0;
            prev_err_q = '0;
         end
         default: ;
      endcase
   endtask

   function automatic drive_type predict_drive(input logic signed [DATA_W-1:0] meas);
      longint err, acc, diff, sum, lim, mag;
      drive_type drv;
      err = longint'(target_q) - longint'(meas);
      acc = longint'(integ_q) + err;
      // upper bound wins when the limits are inverted
      if (acc > longint'(imax_q))
         acc = longint'(imax_q);
      else if (acc < longint'(imin_q))
         acc = longint'(imin_q);
      integ_q = acc[DATA_W-1:0];
      diff = err - longint'(prev_err_q);
      prev_err_q = err[DATA_W:0];
      sum = longint'(kp_q) * err + longint'(ki_q) * acc + longint'(kd_q) * diff;
      lim = longint'(DUTY_LIMIT) << GAIN_FRAC;
      mag = sum;
      if (mag > lim)
         mag = lim;
      else if (mag < -lim)
         mag = -lim;
      if (mag < 0)
         mag = -mag;
      drv.duty    = DUTY_W'(mag >> GAIN_FRAC);
      drv.forward = (sum > 0);
      return drv;
   endfunction

   function automatic logic signed [DATA_W-1:0] clip16(input longint v);
      if (v > 32767)
         return 16'sh7FFF;
      if (v < -32768)
         return 16'sh8000;
      return v[DATA_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_measured();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6)
         return clip16(longint'(target_q) + longint'($urandom_range(0, 600)) - 300);
      if (sel < 9)
         return DATA_W'($urandom());
      case ($urandom_range(0, 2))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         default: return target_q;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_reg_value(input csr_idx_type r);
      case (r)
         CSR_INTEGRATOR_MIN, CSR_INTEGRATOR_MAX: begin
            if ($urandom_range(0, 2) == 0)
               return DATA_W'($urandom());
            return clip16(longint'($urandom_range(0, 128)) - 64);
         end
         CSR_TARGET: begin
            if ($urandom_range(0, 2) == 0)
               return DATA_W'($urandom());
            return clip16(longint'($urandom_range(0, 2000)) - 1000);
         end
         default: begin
            // mostly modest gains so duty lands between the rails
            if ($urandom_range(0, 3) == 0)
               return DATA_W'($urandom());
            return clip16(longint'($urandom_range(0, 1024)) - 512);
         end
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= data;
      apply_reg_write(idx, data);
      @(negedge clock);
   endtask

   task automatic program_phase(input int p);
      logic [CSR_IDX_W-1:0] idx;
      case (p)
         0: begin
            write_reg(CSR_KP_GAIN, 16'sh7FFF);
            write_reg(CSR_KI_GAIN, 16'sh8000);
            write_reg(CSR_KD_GAIN, 16'sh8000);
            write_reg(CSR_INTEGRATOR_MIN, 16'sh8000);
            write_reg(CSR_INTEGRATOR_MAX, 16'sh7FFF);
            write_reg(CSR_TARGET, 16'sh8000);
         end
         1: begin
            // inverted integrator window, setpoint untouched so loop state carries over
            write_reg(CSR_KP_GAIN, 16'sd64);
            write_reg(CSR_KI_GAIN, 16'sd256);
            write_reg(CSR_KD_GAIN, -16'sd32);
            write_reg(CSR_INTEGRATOR_MIN, 16'sd20);
            write_reg(CSR_INTEGRATOR_MAX, -16'sd20);
            write_reg(CSR_SPARE_LO, DATA_W'($urandom()));
            write_reg(CSR_SPARE_HI, DATA_W'($urandom()));
         end
         2: begin
            write_reg(CSR_KP_GAIN, 16'sd0);
            write_reg(CSR_KI_GAIN, 16'sd0);
            write_reg(CSR_KD_GAIN, 16'sd0);
            write_reg(CSR_TARGET, 16'sh7FFF);
         end
         3: begin
            // one LSB of gain: exercises truncation of the duty
            write_reg(CSR_KP_GAIN, 16'sd1);
            write_reg(CSR_KI_GAIN, -16'sd1);
            write_reg(CSR_KD_GAIN, 16'sd1);
            write_reg(CSR_INTEGRATOR_MIN, 16'sh8000);
            write_reg(CSR_INTEGRATOR_MAX, 16'sh7FFF);
            write_reg(CSR_TARGET, 16'sd0);
         end
         default: begin
            for (int i = CSR_KP_GAIN; i <= CSR_TARGET; i++) begin
               if ($urandom_range(0, 3) != 0) begin
                  idx = CSR_IDX_W'(i);
                  write_reg(idx, pick_reg_value(csr_idx_type'(i)));
               end
            end
            if ($urandom_range(0, 3) == 0)
               write_reg($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                         DATA_W'($urandom()));
         end
      endcase
      csr_we <= 1'b0;
   endtask

   // Entered and left on a falling edge; valid stays up for the next item.
   task automatic send_sample(input logic signed [DATA_W-1:0] meas, input logic typed,
                              input logic [DUTY_W-1:0] t_duty, input logic t_fwd);
      int gap;
      drive_type predicted;
      gap = 0;
      if (gaps_on) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
         end else begin
            burst_left--;
         end
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.measured <= meas;
      do
         @(posedge clock);
      while (!req_chan.ready);
      predicted = predict_drive(meas);
      if (typed)
         predicted = '{duty: t_duty, forward: t_fwd};
      pending_drive_q.push_back(predicted);
      samples_sent++;
      @(negedge clock);
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_idx           = '0;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.measured = '0;
      reset_image();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++)
         send_sample(sample_table[r].meas, sample_table[r].typed,
                     sample_table[r].duty, sample_table[r].forward);

      for (int p = 0; p < NUM_PHASES; p++) begin
         req_chan.valid <= 1'b0;
         while (pending_drive_q.size() != 0)
            @(negedge clock);
         program_phase(p);
         settings_used++;
         gaps_on = (p % 3 != 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_sample(pick_measured(), 1'b0, '0, 1'b0);
      end

      req_chan.valid <= 1'b0;
      while (pending_drive_q.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Drove %0d samples over %0d register settings; %0d drive items checked.",
               samples_sent, settings_used, drives_checked);
      $display("Long output hold-offs: %0d; cycles with input backpressured: %0d.",
               long_holds, input_stalls);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Receiver: random ready pattern, with a long hold-off now and then to back up the pipe.
   initial begin : rsp_side
      stall_mode_type mode;
      int mode_left;
      int hold_left;
      int next_hold_at;
      rsp_chan.ready = 1'b0;
      mode           = STALL_NONE;
      mode_left      = 0;
      hold_left      = 0;
      next_hold_at   = 40;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && drives_checked >= next_hold_at) begin
            hold_left    = LONG_HOLD;
            next_hold_at = next_hold_at + 160;
            long_holds++;
         end
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 80);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               STALL_NONE:  rsp_chan.ready <= 1'b1;
               STALL_LIGHT: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               default:     rsp_chan.ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      drive_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_drive_q.size() == 0) begin
            $error("unexpected drive item: duty %0d forward %0b",
                   rsp_chan.duty, rsp_chan.forward);
            mismatches++;
         end else begin
            want = pending_drive_q.pop_front();
            if (rsp_chan.duty !== want.duty) begin
               $error("duty: expected %0d, actual %0d", want.duty, rsp_chan.duty);
               mismatches++;
            end
            if (rsp_chan.forward !== want.forward) begin
               $error("forward: expected %0b, actual %0b", want.forward, rsp_chan.forward);
               mismatches++;
            end
         end
         drives_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (!reset && req_chan.valid && !req_chan.ready)
         input_stalls <= input_stalls + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule
